FILE: hdl/i2c_master_event_sequencer_macros.svh
// ----------------------------------------------------------------------------
// I2C master event sequencer assertion macros
// Concurrent assertion helpers, compiled out when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_EVENT_SEQUENCER_MACROS_SVH
`define I2C_MASTER_EVENT_SEQUENCER_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication, disabled while reset is asserted
`define I2CMES_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("i2cmes assertion failed");
// next-cycle implication, disabled while reset is asserted
`define I2CMES_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("i2cmes assertion failed");
`else
`define I2CMES_ASSERT_NOW(lbl, clk, rstn, ante, cons)
`define I2CMES_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

FILE: hdl/i2cmes_pkg.sv
// ----------------------------------------------------------------------------
// I2C master event sequencer package
// Operation, mode and notify codes plus the item and result structs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package i2cmes_pkg;

    // default transmit buffer depth
    localparam int TX_DEPTH_DEFAULT = 32;

    // operation codes
    localparam logic [2:0] OP_LOAD   = 3'd0;
    localparam logic [2:0] OP_WRITE  = 3'd1;
    localparam logic [2:0] OP_READ   = 3'd2;
    localparam logic [2:0] OP_STATUS = 3'd3;
    localparam logic [2:0] OP_ERROR  = 3'd4;
    localparam logic [2:0] OP_CLOSE  = 3'd5;

    // transfer modes
    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_TX   = 2'd1;
    localparam logic [1:0] MODE_RX   = 2'd2;

    // notify codes
    localparam logic [2:0] NOTE_NONE     = 3'd0;
    localparam logic [2:0] NOTE_TX_DONE  = 3'd1;
    localparam logic [2:0] NOTE_RX_DONE  = 3'd2;
    localparam logic [2:0] NOTE_SLV_REQ  = 3'd3;
    localparam logic [2:0] NOTE_SLV_RCV  = 3'd4;
    localparam logic [2:0] NOTE_STOP_DET = 3'd5;

    // status event flag bit positions
    localparam int FL_SB     = 0;
    localparam int FL_ADDR   = 1;
    localparam int FL_BTF    = 2;
    localparam int FL_STOPF  = 3;
    localparam int FL_TXE    = 4;
    localparam int FL_RXNE   = 5;
    localparam int FL_MASTER = 6;
    localparam int FL_TRA    = 7;

    // one input item
    typedef struct packed {
        logic [2:0]  operation;
        logic [7:0]  data_byte;
        logic [6:0]  slave_address;
        logic [15:0] transfer_length;
        logic        repeated_start;
        logic [7:0]  event_flags;
    } t_item;

    // one result item
    typedef struct packed {
        logic       start_request;
        logic       stop_request;
        logic       ack_enabled;
        logic       irq_enabled;
        logic       dr_write;
        logic [7:0] dr_value;
        logic       address_clear;
        logic       rx_valid;
        logic       rx_last;
        logic [1:0] busy_state;
        logic [2:0] notify_code;
        logic [4:0] error_mask;
    } t_result;

endpackage

FILE: hdl/i2cmes_txbuf.sv
// ----------------------------------------------------------------------------
// I2C master event sequencer transmit buffer
// Single write port, single registered read port, write-to-read bypass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module i2cmes_txbuf #(
    parameter int TX_DEPTH = 32,
    parameter int AW       = 5
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [7:0]    i_wr_data,
    input  logic [AW-1:0] i_rd_addr,
    output logic [7:0]    o_rd_data
);

    logic [7:0] r_mem [TX_DEPTH];
    logic [7:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read, new data wins on an address match
    always_ff @(posedge i_clk) begin
        if (i_wr_en && (i_wr_addr == i_rd_addr)) begin
            r_rd_data <= i_wr_data;
        end else begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: hdl/i2cmes_core.sv
// ----------------------------------------------------------------------------
// I2C master event sequencer core
// Transfer state, per-item decision logic and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "i2c_master_event_sequencer_macros.svh"

module i2cmes_core #(
    parameter int TX_DEPTH = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_item_vld,
    input  i2cmes_pkg::t_item   i_item,
    output logic                o_take,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output i2cmes_pkg::t_result o_result
);
    import i2cmes_pkg::*;

    localparam int AW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
    localparam int CW = $clog2(TX_DEPTH + 1);

    // transfer state
    logic [1:0]    r_mode,      n_mode;
    logic [6:0]    r_tgt_addr,  n_tgt_addr;
    logic          r_keep_bus,  n_keep_bus;
    logic [CW-1:0] r_tx_count,  n_tx_count;
    logic [CW-1:0] r_tx_pos,    n_tx_pos;
    logic [15:0]   r_rd_total,  n_rd_total;
    logic [15:0]   r_rd_left,   n_rd_left;
    logic          r_ack,       n_ack;
    logic          r_irq,       n_irq;

    // result register
    logic          r_out_valid;
    t_result       r_res;
    t_result       n_res;

    // buffer port
    logic          buf_wr_en;
    logic [7:0]    buf_rd_data;

    logic          advance;
    logic          take;

    // flag decode
    logic          fl_sb, fl_ad, fl_btf, fl_stf, fl_txe, fl_rxne, fl_master, fl_tra;
    logic          tx_finish;
    logic [15:0]   left_dec;
    logic [7:0]    rx_byte;

    assign advance = !r_out_valid || !i_out_stall;
    assign take    = i_item_vld && advance;
    assign o_take  = take;

    assign fl_sb     = i_item.event_flags[FL_SB];
    assign fl_ad     = i_item.event_flags[FL_ADDR];
    assign fl_btf    = i_item.event_flags[FL_BTF];
    assign fl_stf    = i_item.event_flags[FL_STOPF];
    assign fl_txe    = i_item.event_flags[FL_TXE];
    assign fl_rxne   = i_item.event_flags[FL_RXNE];
    assign fl_master = i_item.event_flags[FL_MASTER];
    assign fl_tra    = i_item.event_flags[FL_TRA];

    assign tx_finish = fl_btf && (r_mode == MODE_TX) && fl_txe && (r_tx_pos >= r_tx_count);
    assign left_dec  = (r_rd_left != 16'd0) ? (r_rd_left - 16'd1) : r_rd_left;

    assign buf_wr_en = take && (i_item.operation == OP_LOAD) && (r_mode == MODE_IDLE)
                       && (r_tx_count < CW'(TX_DEPTH));

    // per-item decision
    always_comb begin
        n_mode     = r_mode;
        n_tgt_addr = r_tgt_addr;
        n_keep_bus = r_keep_bus;
        n_tx_count = r_tx_count;
        n_tx_pos   = r_tx_pos;
        n_rd_total = r_rd_total;
        n_rd_left  = r_rd_left;
        n_ack      = r_ack;
        n_irq      = r_irq;
        n_res      = '0;
        rx_byte    = 8'd0;

        if (take) begin
            unique case (i_item.operation)
                OP_LOAD: begin
                    if (buf_wr_en) begin
                        n_tx_count = r_tx_count + CW'(1);
                    end
                end
                OP_WRITE: begin
                    if (r_mode == MODE_IDLE) begin
                        n_tgt_addr = i_item.slave_address;
                        n_keep_bus = i_item.repeated_start;
                        n_mode     = MODE_TX;
                        n_tx_pos   = '0;
                        n_irq      = 1'b1;
                        n_res.start_request = 1'b1;
                    end
                end
                OP_READ: begin
                    if ((r_mode == MODE_IDLE) && (i_item.transfer_length != 16'd0)) begin
                        n_tgt_addr = i_item.slave_address;
                        n_keep_bus = i_item.repeated_start;
                        n_mode     = MODE_RX;
                        n_rd_total = i_item.transfer_length;
                        n_rd_left  = i_item.transfer_length;
                        n_irq      = 1'b1;
                        n_res.start_request = 1'b1;
                    end
                end
                OP_STATUS: begin
                    if (r_irq) begin
                        // start bit: send address with R/W
                        if (fl_sb && fl_master) begin
                            n_res.dr_write = 1'b1;
                            n_res.dr_value = {r_tgt_addr, (r_mode != MODE_TX)};
                        end
                        // address phase
                        if (fl_ad) begin
                            if (fl_master && (r_mode == MODE_RX) && (r_rd_total == 16'd1)) begin
                                n_ack = 1'b0;
                            end
                            n_res.address_clear = 1'b1;
                        end
                        // write complete
                        if (tx_finish) begin
                            n_res.stop_request = 1'b1;
                            n_irq      = 1'b0;
                            n_mode     = MODE_IDLE;
                            n_tx_count = '0;
                            n_tx_pos   = '0;
                            n_rd_total = '0;
                            n_rd_left  = '0;
                            n_res.notify_code = NOTE_TX_DONE;
                        end
                        if (fl_stf && !fl_master) begin
                            n_res.notify_code = NOTE_STOP_DET;
                        end
                        // buffer events, only while still enabled
                        if (!tx_finish) begin
                            if (fl_txe) begin
                                if (fl_master) begin
                                    if ((r_mode == MODE_TX) && (r_tx_pos < r_tx_count)) begin
                                        n_res.dr_write = 1'b1;
                                        n_res.dr_value = buf_rd_data;
                                        n_tx_pos       = r_tx_pos + CW'(1);
                                    end
                                end else if (fl_tra) begin
                                    n_res.notify_code = NOTE_SLV_REQ;
                                end
                            end
                            if (fl_rxne) begin
                                if (fl_master) begin
                                    if (r_mode == MODE_RX) begin
                                        n_res.rx_valid = 1'b1;
                                        rx_byte        = i_item.data_byte;
                                        n_rd_left      = left_dec;
                                        if ((r_rd_total > 16'd1) && (left_dec == 16'd1)) begin
                                            n_ack = 1'b0;
                                        end
                                        if (left_dec == 16'd0) begin
                                            n_res.stop_request = !r_keep_bus;
                                            n_irq      = 1'b0;
                                            n_ack      = 1'b1;
                                            n_mode     = MODE_IDLE;
                                            n_tx_count = '0;
                                            n_tx_pos   = '0;
                                            n_rd_total = '0;
                                            n_rd_left  = '0;
                                            n_res.notify_code = NOTE_RX_DONE;
                                            n_res.rx_last     = 1'b1;
                                        end
                                    end
                                end else if (!fl_tra) begin
                                    n_res.notify_code = NOTE_SLV_RCV;
                                end
                            end
                        end
                        // received byte rides on dr_value when nothing is written
                        if (!n_res.dr_write && n_res.rx_valid) begin
                            n_res.dr_value = rx_byte;
                        end
                    end
                end
                OP_ERROR: begin
                    if (r_irq) begin
                        n_res.error_mask = i_item.event_flags[4:0];
                        n_mode     = MODE_IDLE;
                        n_tx_count = '0;
                        n_tx_pos   = '0;
                        n_rd_total = '0;
                        n_rd_left  = '0;
                    end
                end
                OP_CLOSE: begin
                    n_res.stop_request = fl_master;
                    n_irq      = 1'b0;
                    n_ack      = 1'b1;
                    n_mode     = MODE_IDLE;
                    n_tx_count = '0;
                    n_tx_pos   = '0;
                    n_rd_total = '0;
                    n_rd_left  = '0;
                    n_tgt_addr = '0;
                    n_keep_bus = 1'b0;
                end
                default: begin
                    // unused codes: status only
                end
            endcase
        end

        n_res.ack_enabled = n_ack;
        n_res.irq_enabled = n_irq;
        n_res.busy_state  = n_mode;
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_IDLE;
            r_tgt_addr <= '0;
            r_keep_bus <= 1'b0;
            r_tx_count <= '0;
            r_tx_pos   <= '0;
            r_rd_total <= '0;
            r_rd_left  <= '0;
            r_ack      <= 1'b1;
            r_irq      <= 1'b0;
        end else begin
            r_mode     <= n_mode;
            r_tgt_addr <= n_tgt_addr;
            r_keep_bus <= n_keep_bus;
            r_tx_count <= n_tx_count;
            r_tx_pos   <= n_tx_pos;
            r_rd_total <= n_rd_total;
            r_rd_left  <= n_rd_left;
            r_ack      <= n_ack;
            r_irq      <= n_irq;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= i_item_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_res <= n_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_res;

    // transmit buffer, read address follows the next position
    i2cmes_txbuf #(
        .TX_DEPTH (TX_DEPTH),
        .AW       (AW)
    ) u_txbuf (
        .i_clk     (i_clk),
        .i_wr_en   (buf_wr_en),
        .i_wr_addr (r_tx_count[AW-1:0]),
        .i_wr_data (i_item.data_byte),
        .i_rd_addr (n_tx_pos[AW-1:0]),
        .o_rd_data (buf_rd_data)
    );

    // checks
    `I2CMES_ASSERT_NOW(a_pos_le_count, i_clk, i_rst_n, 1'b1, r_tx_pos <= r_tx_count)
    `I2CMES_ASSERT_NOW(a_idle_clean, i_clk, i_rst_n, r_mode == MODE_IDLE, (r_tx_pos == '0) && (r_rd_left == 16'd0))
    `I2CMES_ASSERT_NOW(a_irq_off_idle, i_clk, i_rst_n, !r_irq, r_mode == MODE_IDLE)
    `I2CMES_ASSERT_NOW(a_last_is_done, i_clk, i_rst_n, r_out_valid && r_res.rx_last, r_res.rx_valid && (r_res.notify_code == NOTE_RX_DONE) && (r_res.busy_state == MODE_IDLE))
    `I2CMES_ASSERT_NEXT(a_out_held, i_clk, i_rst_n, r_out_valid && i_out_stall, r_out_valid)

endmodule

FILE: hdl/i2c_master_event_sequencer.sv
// A result passes through the input register, then the result register behind the single
// decision stage.
// Throughput: one item per cycle unless the result side stalls.
// Reset: synchronous, active low; clears transfer state and handshake control.
// The transmit buffer is not cleared; entries read only after being loaded.
// ----------------------------------------------------------------------------
// I2C master event sequencer
// Interrupt-driven I2C master transfer sequencing from commands and bus events.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module i2c_master_event_sequencer #(
    parameter int TX_DEPTH = i2cmes_pkg::TX_DEPTH_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input item channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_operation,
    input  logic [7:0]  i_data_byte,
    input  logic [6:0]  i_slave_address,
    input  logic [15:0] i_transfer_length,
    input  logic        i_repeated_start,
    input  logic [7:0]  i_event_flags,
    // result item channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_start_request,
    output logic        o_stop_request,
    output logic        o_ack_enabled,
    output logic        o_irq_enabled,
    output logic        o_dr_write,
    output logic [7:0]  o_dr_value,
    output logic        o_address_clear,
    output logic        o_rx_valid,
    output logic        o_rx_last,
    output logic [1:0]  o_busy_state,
    output logic [2:0]  o_notify_code,
    output logic [4:0]  o_error_mask
);
    import i2cmes_pkg::*;

    logic    r_in_vld;
    t_item   r_in_item;
    logic    core_take;
    t_result core_res;
    logic    in_accept;

    assign o_in_stall = r_in_vld && !core_take;
    assign in_accept  = i_in_valid && !o_in_stall;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_accept) begin
            r_in_vld <= 1'b1;
        end else if (core_take) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_item.operation       <= i_operation;
            r_in_item.data_byte       <= i_data_byte;
            r_in_item.slave_address   <= i_slave_address;
            r_in_item.transfer_length <= i_transfer_length;
            r_in_item.repeated_start  <= i_repeated_start;
            r_in_item.event_flags     <= i_event_flags;
        end
    end

    // sequencing core
    i2cmes_core #(
        .TX_DEPTH (TX_DEPTH)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item_vld  (r_in_vld),
        .i_item      (r_in_item),
        .o_take      (core_take),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_result    (core_res)
    );

    // result fields
    assign o_start_request = core_res.start_request;
    assign o_stop_request  = core_res.stop_request;
    assign o_ack_enabled   = core_res.ack_enabled;
    assign o_irq_enabled   = core_res.irq_enabled;
    assign o_dr_write      = core_res.dr_write;
    assign o_dr_value      = core_res.dr_value;
    assign o_address_clear = core_res.address_clear;
    assign o_rx_valid      = core_res.rx_valid;
    assign o_rx_last       = core_res.rx_last;
    assign o_busy_state    = core_res.busy_state;
    assign o_notify_code   = core_res.notify_code;
    assign o_error_mask    = core_res.error_mask;

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master event sequencer testbench
// A directed opening, then random write, read and slave-side event bursts mixed
// with noise, sent over the valid/stall item channel with random gaps and
// output stalls. An in-bench model predicts every result item, and each field
// is compared against the oldest pending prediction.
// ----------------------------------------------------------------------------

module tb;
    import i2cmes_pkg::*;

    localparam int BUF_DEPTH    = TX_DEPTH_DEFAULT;
    localparam int N_RANDOM     = 1550;
    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 8;

    // unused operation codes
    localparam logic [2:0] OP_RSVD6 = 3'd6;
    localparam logic [2:0] OP_RSVD7 = 3'd7;

    // status flag masks
    localparam logic [7:0] F_SB    = 8'(1 << FL_SB);
    localparam logic [7:0] F_ADDR  = 8'(1 << FL_ADDR);
    localparam logic [7:0] F_BTF   = 8'(1 << FL_BTF);
    localparam logic [7:0] F_STOPF = 8'(1 << FL_STOPF);
    localparam logic [7:0] F_TXE   = 8'(1 << FL_TXE);
    localparam logic [7:0] F_RXNE  = 8'(1 << FL_RXNE);
    localparam logic [7:0] F_MST   = 8'(1 << FL_MASTER);
    localparam logic [7:0] F_TRA   = 8'(1 << FL_TRA);
    localparam logic [7:0] ERR_ALL = 8'h1F;

    typedef struct {
        t_item it;
        bit    drain_first;
    } t_pending;

    // clock, reset and DUT pins
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [2:0]  i_operation = '0;
    logic [7:0]  i_data_byte = '0;
    logic [6:0]  i_slave_address = '0;
    logic [15:0] i_transfer_length = '0;
    logic        i_repeated_start = 1'b0;
    logic [7:0]  i_event_flags = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic        o_start_request;
    logic        o_stop_request;
    logic        o_ack_enabled;
    logic        o_irq_enabled;
    logic        o_dr_write;
    logic [7:0]  o_dr_value;
    logic        o_address_clear;
    logic        o_rx_valid;
    logic        o_rx_last;
    logic [1:0]  o_busy_state;
    logic [2:0]  o_notify_code;
    logic [4:0]  o_error_mask;

    // bench bookkeeping
    t_pending item_backlog[$];
    t_result  results_due[$];
    int       n_queued = 0;
    int       items_sent = 0;
    int       mismatches = 0;
    int       quiet_cycles = 0;
    logic     in_taken = 1'b0;
    wire      calm = (items_sent >= 600) && (items_sent < 900);

    // model state
    logic [1:0]  sq_mode = MODE_IDLE;
    logic [6:0]  sq_addr = '0;
    logic        sq_keep = 1'b0;
    logic [7:0]  sq_buf [BUF_DEPTH];
    logic [5:0]  sq_tx_cnt = '0;
    logic [5:0]  sq_tx_pos = '0;
    logic [15:0] sq_rd_total = '0;
    logic [15:0] sq_rd_left = '0;
    logic        sq_ack = 1'b1;
    logic        sq_irq = 1'b0;

    i2c_master_event_sequencer u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_operation       (i_operation),
        .i_data_byte       (i_data_byte),
        .i_slave_address   (i_slave_address),
        .i_transfer_length (i_transfer_length),
        .i_repeated_start  (i_repeated_start),
        .i_event_flags     (i_event_flags),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_start_request   (o_start_request),
        .o_stop_request    (o_stop_request),
        .o_ack_enabled     (o_ack_enabled),
        .o_irq_enabled     (o_irq_enabled),
        .o_dr_write        (o_dr_write),
        .o_dr_value        (o_dr_value),
        .o_address_clear   (o_address_clear),
        .o_rx_valid        (o_rx_valid),
        .o_rx_last         (o_rx_last),
        .o_busy_state      (o_busy_state),
        .o_notify_code     (o_notify_code),
        .o_error_mask      (o_error_mask)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // transfer teardown: back to idle, counters cleared
    function automatic void end_transfer();
        sq_mode     = MODE_IDLE;
        sq_tx_cnt   = '0;
        sq_tx_pos   = '0;
        sq_rd_total = '0;
        sq_rd_left  = '0;
    endfunction

    // advance the model by one item and return the result it gives
    function automatic t_result next_sequencer_result(t_item it);
        t_result    r;
        logic [7:0] fl;
        logic       mst;
        logic       tra;
        logic [7:0] rx_byte;
        r       = '0;
        fl      = it.event_flags;
        mst     = fl[FL_MASTER];
        tra     = fl[FL_TRA];
        rx_byte = '0;
        case (it.operation)
            OP_LOAD: begin
                if (sq_mode == MODE_IDLE && sq_tx_cnt < 6'(BUF_DEPTH)) begin
                    sq_buf[sq_tx_cnt[4:0]] = it.data_byte;
                    sq_tx_cnt = sq_tx_cnt + 6'd1;
                end
            end
            OP_WRITE: begin
                if (sq_mode == MODE_IDLE) begin
                    sq_addr         = it.slave_address;
                    sq_keep         = it.repeated_start;
                    sq_mode         = MODE_TX;
                    sq_tx_pos       = '0;
                    sq_irq          = 1'b1;
                    r.start_request = 1'b1;
                end
            end
            OP_READ: begin
                if (sq_mode == MODE_IDLE && it.transfer_length != 16'd0) begin
                    sq_addr         = it.slave_address;
                    sq_keep         = it.repeated_start;
                    sq_mode         = MODE_RX;
                    sq_rd_total     = it.transfer_length;
                    sq_rd_left      = it.transfer_length;
                    sq_irq          = 1'b1;
                    r.start_request = 1'b1;
                end
            end
            OP_STATUS: begin
                if (sq_irq) begin
                    // start bit: address byte, R/W low only for a write
                    if (fl[FL_SB] && mst) begin
                        r.dr_write = 1'b1;
                        r.dr_value = {sq_addr, (sq_mode != MODE_TX)};
                    end
                    if (fl[FL_ADDR]) begin
                        if (mst && sq_mode == MODE_RX && sq_rd_total == 16'd1)
                            sq_ack = 1'b0;
                        r.address_clear = 1'b1;
                    end
                    // last byte shifted out
                    if (fl[FL_BTF] && sq_mode == MODE_TX && fl[FL_TXE] &&
                        sq_tx_pos >= sq_tx_cnt) begin
                        r.stop_request = 1'b1;
                        sq_irq         = 1'b0;
                        end_transfer();
                        r.notify_code  = NOTE_TX_DONE;
                    end
                    if (fl[FL_STOPF] && !mst)
                        r.notify_code = NOTE_STOP_DET;
                    // buffer events only while interrupts remain on
                    if (sq_irq) begin
                        if (fl[FL_TXE]) begin
                            if (mst) begin
                                if (sq_mode == MODE_TX && sq_tx_pos < sq_tx_cnt &&
                                    sq_tx_pos < 6'(BUF_DEPTH)) begin
                                    r.dr_write = 1'b1;
                                    r.dr_value = sq_buf[sq_tx_pos[4:0]];
                                    sq_tx_pos  = sq_tx_pos + 6'd1;
                                end
                            end else if (tra) begin
                                r.notify_code = NOTE_SLV_REQ;
                            end
                        end
                        if (fl[FL_RXNE]) begin
                            if (mst) begin
                                if (sq_mode == MODE_RX) begin
                                    r.rx_valid = 1'b1;
                                    rx_byte    = it.data_byte;
                                    if (sq_rd_left != 16'd0)
                                        sq_rd_left = sq_rd_left - 16'd1;
                                    if (sq_rd_total > 16'd1 && sq_rd_left == 16'd1)
                                        sq_ack = 1'b0;
                                    if (sq_rd_left == 16'd0) begin
                                        if (!sq_keep)
                                            r.stop_request = 1'b1;
                                        sq_irq = 1'b0;
                                        sq_ack = 1'b1;
                                        end_transfer();
                                        r.notify_code = NOTE_RX_DONE;
                                        r.rx_last     = 1'b1;
                                    end
                                end
                            end else if (!tra) begin
                                r.notify_code = NOTE_SLV_RCV;
                            end
                        end
                    end
                    if (!r.dr_write && r.rx_valid)
                        r.dr_value = rx_byte;
                end
            end
            OP_ERROR: begin
                if (sq_irq) begin
                    r.error_mask = fl[4:0];
                    end_transfer();
                end
            end
            OP_CLOSE: begin
                r.stop_request = mst;
                sq_irq = 1'b0;
                sq_ack = 1'b1;
                end_transfer();
                sq_addr = '0;
                sq_keep = 1'b0;
            end
            default: ;
        endcase
        r.ack_enabled = sq_ack;
        r.irq_enabled = sq_irq;
        r.busy_state  = sq_mode;
        return r;
    endfunction

    function automatic t_item mk(logic [2:0] op, logic [7:0] d, logic [6:0] a,
                                 logic [15:0] len, logic rs, logic [7:0] fl);
        t_item it;
        it.operation       = op;
        it.data_byte       = d;
        it.slave_address   = a;
        it.transfer_length = len;
        it.repeated_start  = rs;
        it.event_flags     = fl;
        return it;
    endfunction

    function automatic t_item rnd_item(logic [2:0] op);
        return mk(op, 8'($urandom), 7'($urandom), 16'($urandom), 1'($urandom),
                  8'($urandom));
    endfunction

    function automatic logic [7:0] maybe_tra();
        return ($urandom_range(1) == 1) ? F_TRA : 8'h00;
    endfunction

    // status event with random payload and the given flags
    function automatic t_item status_item(logic [7:0] fl);
        t_item it;
        it = rnd_item(OP_STATUS);
        it.event_flags = fl;
        return it;
    endfunction

    // a few items along the way wait for the block to drain first
    task automatic queue_item(input t_item it);
        t_pending p;
        p.it          = it;
        p.drain_first = (n_queued % 400) == 200;
        item_backlog.insert(item_backlog.size(), p);
        n_queued++;
    endtask

    task automatic check_field(input string fname, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, fname, want, got);
            mismatches++;
        end
    endtask

    // driver: present the next item once the current one is taken
    always @(negedge i_clk) begin : p_driver
        t_pending nx;
        if (i_rst_n) begin
            if (!i_in_valid || in_taken) begin
                if (item_backlog.size() != 0 &&
                    !(item_backlog[0].drain_first && results_due.size() != 0) &&
                    (calm || $urandom_range(99) >= 26)) begin
                    nx = item_backlog.pop_front();
                    {i_operation, i_data_byte, i_slave_address, i_transfer_length,
                     i_repeated_start, i_event_flags} <= nx.it;
                    i_in_valid <= 1'b1;
                    items_sent <= items_sent + 1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // result side back-pressure
    always @(negedge i_clk) begin
        if (i_rst_n)
            i_out_stall <= !calm && ($urandom_range(99) < 26);
    end

    // monitor: check results, then predict for the item taken this edge
    always @(posedge i_clk) begin : p_monitor
        t_item   acc;
        t_result got;
        t_result want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                got = {o_start_request, o_stop_request, o_ack_enabled, o_irq_enabled,
                       o_dr_write, o_dr_value, o_address_clear, o_rx_valid, o_rx_last,
                       o_busy_state, o_notify_code, o_error_mask};
                if (results_due.size() == 0) begin
                    $display("%0t ns: unexpected result, expected none, actual 0x%0h",
                             $time, got);
                    mismatches++;
                end else begin
                    want = results_due.pop_front();
                    check_field("start_request", want.start_request, got.start_request);
                    check_field("stop_request", want.stop_request, got.stop_request);
                    check_field("ack_enabled", want.ack_enabled, got.ack_enabled);
                    check_field("irq_enabled", want.irq_enabled, got.irq_enabled);
                    check_field("dr_write", want.dr_write, got.dr_write);
                    check_field("dr_value", want.dr_value, got.dr_value);
                    check_field("address_clear", want.address_clear, got.address_clear);
                    check_field("rx_valid", want.rx_valid, got.rx_valid);
                    check_field("rx_last", want.rx_last, got.rx_last);
                    check_field("busy_state", want.busy_state, got.busy_state);
                    check_field("notify_code", want.notify_code, got.notify_code);
                    check_field("error_mask", want.error_mask, got.error_mask);
                end
            end
            if (i_in_valid && !o_in_stall) begin
                acc = {i_operation, i_data_byte, i_slave_address, i_transfer_length,
                       i_repeated_start, i_event_flags};
                results_due.insert(results_due.size(), next_sequencer_result(acc));
            end
            in_taken <= i_in_valid && !o_in_stall;
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= QUIET_LIMIT) begin
                $display("[i2c_master_event_sequencer] ERROR");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin : p_stimulus
        t_item it;
        int    first_random;
        int    pick;
        int    n;
        int    len;
        int    rx_n;

        // idle bus: close, then events and unused codes with interrupts off
        queue_item(mk(OP_CLOSE, 8'h00, 7'h00, 16'h0000, 1'b0, F_MST));
        queue_item(mk(OP_STATUS, 8'hFF, 7'h7F, 16'hFFFF, 1'b1, 8'hFF));
        queue_item(mk(OP_ERROR, 8'h00, 7'h00, 16'h0000, 1'b0, ERR_ALL));
        queue_item(mk(OP_RSVD6, 8'hFF, 7'h7F, 16'hFFFF, 1'b1, 8'hFF));
        queue_item(mk(OP_RSVD7, 8'h00, 7'h00, 16'h0000, 1'b0, 8'h00));
        // loads, and a read of length zero
        queue_item(mk(OP_LOAD, 8'h00, 7'h00, 16'h0000, 1'b0, 8'h00));
        queue_item(mk(OP_LOAD, 8'hFF, 7'h00, 16'h0000, 1'b0, 8'h00));
        queue_item(mk(OP_READ, 8'h00, 7'h12, 16'h0000, 1'b0, 8'h00));
        // write to the top address; begins and loads while busy do nothing
        queue_item(mk(OP_WRITE, 8'h00, 7'h7F, 16'h0000, 1'b0, 8'h00));
        queue_item(mk(OP_WRITE, 8'h00, 7'h01, 16'h0000, 1'b1, 8'h00));
        queue_item(mk(OP_READ, 8'h00, 7'h02, 16'h0005, 1'b0, 8'h00));
        queue_item(mk(OP_LOAD, 8'h55, 7'h00, 16'h0000, 1'b0, 8'h00));
        // start and first data in one event: the data byte wins
        queue_item(status_item(F_MST | F_TRA | F_SB | F_TXE));
        queue_item(status_item(F_MST | F_TRA | F_ADDR));
        queue_item(status_item(F_MST | F_TRA | F_TXE));
        queue_item(status_item(F_MST | F_TRA | F_BTF | F_TXE));
        // one-byte read, repeated start: NACK set at address, no stop at the end
        queue_item(mk(OP_READ, 8'h00, 7'h00, 16'h0001, 1'b1, 8'h00));
        queue_item(status_item(F_MST | F_SB | F_ADDR));
        queue_item(mk(OP_STATUS, 8'hFF, 7'h00, 16'h0000, 1'b0, F_MST | F_RXNE));
        // longest read cut by all errors at once; interrupts stay enabled
        queue_item(mk(OP_READ, 8'h00, 7'h55, 16'hFFFF, 1'b0, 8'h00));
        queue_item(mk(OP_ERROR, 8'h00, 7'h00, 16'h0000, 1'b0, ERR_ALL));
        // start bit while idle: address goes out as a read
        queue_item(status_item(F_MST | F_SB));
        // slave side: stop then data request in one event, receive, stop alone
        queue_item(status_item(F_TRA | F_STOPF | F_TXE));
        queue_item(mk(OP_STATUS, 8'hA5, 7'h00, 16'h0000, 1'b0, F_RXNE));
        queue_item(status_item(F_STOPF));
        queue_item(mk(OP_CLOSE, 8'h00, 7'h00, 16'h0000, 1'b0, 8'h00));

        first_random = n_queued;
        while (n_queued < first_random + N_RANDOM) begin
            pick = $urandom_range(99);
            if (pick < 35) begin
                // write: fill, begin, start, address, data bytes, finish
                if ($urandom_range(9) < 6)
                    queue_item(rnd_item(OP_CLOSE));
                n = ($urandom_range(9) == 0) ? $urandom_range(25, 40) : $urandom_range(0, 5);
                repeat (n) queue_item(rnd_item(OP_LOAD));
                queue_item(rnd_item(OP_WRITE));
                queue_item(status_item(F_MST | F_SB | maybe_tra()));
                queue_item(status_item(F_MST | F_ADDR | maybe_tra()));
                repeat (n)
                    queue_item(status_item(F_MST | F_TXE | maybe_tra() |
                                           (($urandom_range(7) == 0) ? F_BTF : 8'h00)));
                case ($urandom_range(9))
                    0: queue_item(rnd_item(OP_ERROR));
                    1: queue_item(rnd_item(OP_CLOSE));
                    default: queue_item(status_item(F_MST | F_BTF | F_TXE | maybe_tra()));
                endcase
            end else if (pick < 65) begin
                // read: begin, start and address, then received bytes
                if ($urandom_range(9) < 6)
                    queue_item(rnd_item(OP_CLOSE));
                n = $urandom_range(19);
                len = (n < 14) ? $urandom_range(1, 4) :
                      (n < 18) ? $urandom_range(5, 20) : $urandom_range(0, 65535);
                it = rnd_item(OP_READ);
                it.transfer_length = 16'(len);
                queue_item(it);
                if ($urandom_range(3) == 0) begin
                    queue_item(status_item(F_MST | F_SB | F_ADDR));
                end else begin
                    queue_item(status_item(F_MST | F_SB));
                    queue_item(status_item(F_MST | F_ADDR | maybe_tra()));
                end
                rx_n = (len > 24) ? $urandom_range(1, 6) : len;
                repeat (rx_n) queue_item(status_item(F_MST | F_RXNE | maybe_tra()));
                // long reads end early
                if (len > 24)
                    queue_item(rnd_item(($urandom_range(1) == 1) ? OP_ERROR : OP_CLOSE));
            end else if (pick < 80) begin
                // slave-side events while interrupts are on
                if ($urandom_range(1) == 1)
                    queue_item(rnd_item(OP_CLOSE));
                queue_item(rnd_item(OP_READ));
                repeat ($urandom_range(1, 4)) begin
                    it = rnd_item(OP_STATUS);
                    it.event_flags[FL_MASTER] = 1'b0;
                    queue_item(it);
                end
                it = rnd_item(OP_CLOSE);
                it.event_flags[FL_MASTER] = 1'b0;
                queue_item(it);
            end else begin
                // noise: any code, any fields
                repeat ($urandom_range(1, 3)) queue_item(rnd_item(3'($urandom_range(7))));
            end
        end

        // reset held, then released on a falling edge
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (item_backlog.size() != 0 || i_in_valid)
            @(posedge i_clk);
        while (results_due.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && results_due.size() == 0) begin
            $display("[i2c_master_event_sequencer] OK");
        end else begin
            $display("[i2c_master_event_sequencer] ERROR");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/i2cmes_pkg.sv
hdl/i2cmes_txbuf.sv
hdl/i2cmes_core.sv
hdl/i2c_master_event_sequencer.sv
dv/tb.sv
